@@ design/rfac_pkg.sv @@
`default_nettype none

package rfac_pkg;

  // Field and datapath widths
  localparam int DataW       = 32;
  localparam int FuncW       = 3;
  localparam int FieldIdxW   = 4;
  localparam int NumSlotsDef = 10;

  // Bus widths, padded to whole bytes
  localparam int InBits  = FuncW + 3 * FieldIdxW + DataW;
  localparam int OutBits = 1 + FieldIdxW + 2 * DataW;
  localparam int InW     = ((InBits + 7) / 8) * 8;
  localparam int OutW    = ((OutBits + 7) / 8) * 8;

  // Operation codes
  typedef enum logic [FuncW-1:0] {
    FN_LOAD = 3'd0,
    FN_READ = 3'd1,
    FN_ADD  = 3'd2,
    FN_SUB  = 3'd3,
    FN_MUL  = 3'd4,
    FN_DIV  = 3'd5
  } func_e;

  // Sequencer to arithmetic unit
  typedef struct packed {
    logic  start;
    func_e op;
  } alu_req_t;

  // Arithmetic unit back to sequencer
  typedef struct packed {
    logic done;
    logic wr_ok;
  } alu_rsp_t;

endpackage

`default_nettype wire

@@ design/rfac_regfile.sv @@
`default_nettype none

module rfac_regfile import rfac_pkg::*; #(
  parameter  int NUM_SLOTS = NumSlotsDef,
  localparam int RfIdxW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [RfIdxW-1:0]      rd_a_addr_i,
  input  wire logic [RfIdxW-1:0]      rd_b_addr_i,
  output logic      [DataW-1:0]       rd_a_data_o,
  output logic      [DataW-1:0]       rd_b_data_o,
  input  wire logic                   wr_en_i,
  input  wire logic [RfIdxW-1:0]      wr_addr_i,
  input  wire logic [DataW-1:0]       wr_data_i
);

  logic [DataW-1:0] mem_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] vld_q;
  logic [DataW-1:0] rd_a_q, rd_b_q;

  // Slot storage, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Written marks; an unwritten slot reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  // Registered read ports
  always_ff @(posedge clk_i) begin
    rd_a_q <= vld_q[rd_a_addr_i] ? mem_q[rd_a_addr_i] : '0;
    rd_b_q <= vld_q[rd_b_addr_i] ? mem_q[rd_b_addr_i] : '0;
  end

  assign rd_a_data_o = rd_a_q;
  assign rd_b_data_o = rd_b_q;

endmodule

`default_nettype wire

@@ design/rfac_alu.sv @@
`default_nettype none

module rfac_alu import rfac_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire alu_req_t         req_i,
  input  wire logic [DataW-1:0] a_i,
  input  wire logic [DataW-1:0] b_i,
  output alu_rsp_t              rsp_o,
  output logic      [DataW-1:0] res_o
);

  localparam int CntW = $clog2(DataW);
  localparam logic [CntW-1:0] LastStep = CntW'(DataW - 1);

  typedef enum logic [5:0] {
    A_IDLE  = 6'b000001,
    A_ARITH = 6'b000010,
    A_NEGA  = 6'b000100,
    A_NEGB  = 6'b001000,
    A_LOOP  = 6'b010000,
    A_NEGQ  = 6'b100000
  } alu_state_e;

  alu_state_e state_q, state_d;
  func_e op_q, op_d;
  logic [DataW-1:0] x_q, x_d;   // accumulator / partial remainder
  logic [DataW-1:0] y_q, y_d;   // multiplicand / dividend, then quotient
  logic [DataW-1:0] z_q, z_d;   // multiplier / divisor magnitude
  logic [DataW-1:0] res_q, res_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic neg_q, neg_d, dz_q, dz_d, done_q, done_d;

  // The one shared adder
  logic [DataW:0]   add_a, add_b;
  logic             add_ci;
  logic [DataW+1:0] add_s;
  logic             carry;

  assign add_s = {1'b0, add_a} + {1'b0, add_b} + {{(DataW+1){1'b0}}, add_ci};
  assign carry = add_s[DataW+1];

  // Adder operand select
  always_comb begin
    add_a  = '0;
    add_b  = '0;
    add_ci = 1'b0;
    case (state_q)
      A_ARITH: begin
        add_a  = {1'b0, y_q};
        add_b  = {1'b0, (op_q == FN_SUB) ? ~z_q : z_q};
        add_ci = (op_q == FN_SUB);
      end
      A_NEGA: begin
        add_b  = {1'b0, ~y_q};
        add_ci = 1'b1;
      end
      A_NEGB: begin
        add_b  = {1'b0, ~z_q};
        add_ci = 1'b1;
      end
      A_NEGQ: begin
        add_b  = {1'b0, ~y_q};
        add_ci = 1'b1;
      end
      A_LOOP: begin
        if (op_q == FN_DIV) begin
          // trial subtract of divisor from shifted remainder
          add_a  = {x_q, y_q[DataW-1]};
          add_b  = ~{1'b0, z_q};
          add_ci = 1'b1;
        end else begin
          add_a = {1'b0, x_q};
          add_b = {1'b0, y_q};
        end
      end
      default: ;
    endcase
  end

  // Sequencer and operand registers
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    res_d   = res_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    dz_d    = dz_q;
    done_d  = 1'b0;
    case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          op_d  = req_i.op;
          x_d   = '0;
          y_d   = a_i;
          z_d   = b_i;
          cnt_d = '0;
          neg_d = a_i[DataW-1] ^ b_i[DataW-1];
          dz_d  = (b_i == '0);
          case (req_i.op)
            FN_MUL:  state_d = A_LOOP;
            FN_DIV:  state_d = A_NEGA;
            default: state_d = A_ARITH;
          endcase
        end
      end
      A_ARITH: begin
        res_d   = add_s[DataW-1:0];
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      A_NEGA: begin
        if (y_q[DataW-1]) begin
          y_d = add_s[DataW-1:0];
        end
        state_d = A_NEGB;
      end
      A_NEGB: begin
        if (z_q[DataW-1]) begin
          z_d = add_s[DataW-1:0];
        end
        state_d = A_LOOP;
      end
      A_LOOP: begin
        cnt_d = cnt_q + 1'b1;
        if (op_q == FN_DIV) begin
          x_d = carry ? add_s[DataW-1:0] : {x_q[DataW-2:0], y_q[DataW-1]};
          y_d = {y_q[DataW-2:0], carry};
          if (cnt_q == LastStep) begin
            state_d = A_NEGQ;
          end
        end else begin
          // shift-add multiply, low word only
          if (z_q[0]) begin
            x_d = add_s[DataW-1:0];
          end
          y_d = {y_q[DataW-2:0], 1'b0};
          z_d = {1'b0, z_q[DataW-1:1]};
          if (cnt_q == LastStep) begin
            res_d   = x_d;
            done_d  = 1'b1;
            state_d = A_IDLE;
          end
        end
      end
      A_NEGQ: begin
        res_d   = neg_q ? add_s[DataW-1:0] : y_q;
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    res_q <= res_d;
    cnt_q <= cnt_d;
    neg_q <= neg_d;
    dz_q  <= dz_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.wr_ok = !((op_q == FN_DIV) && dz_q);
  assign res_o       = res_q;

endmodule

`default_nettype wire

@@ design/register_file_alu_calculator.sv @@
// Channel | Dir | Transfer when            | Payload
// s_axis  | in  | s_axis_tvalid & tready   | func, src_a, src_b, dest, immediate
// m_axis  | out | m_axis_tvalid & tready   | read_valid, read_index, read_value, slot_total
//
// One item at a time; s_axis_tready is high only while the sequencer is idle.
// Multiply and divide run on the shared adder,
// stepping one multiplier or quotient bit per cycle.
// Reset clears all slots (written marks) and the running total at once.
// A result waits in the output register; a held output stalls the next result.
`default_nettype none

module register_file_alu_calculator import rfac_pkg::*; #(
  parameter int NUM_SLOTS = NumSlotsDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  // func[2:0], src_a[6:3], src_b[10:7], dest[14:11], immediate[46:15], zero pad
  input  wire logic [InW-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  // read_valid[0], read_index[4:1], read_value[36:5], slot_total[68:37], zero pad
  output logic      [OutW-1:0] m_axis_tdata
);

  localparam int RfIdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [FieldIdxW:0] SlotLim = (FieldIdxW+1)'(NUM_SLOTS);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_RDAB = 7'b0000010,
    ST_OPS  = 7'b0000100,
    ST_EXEC = 7'b0001000,
    ST_RDD  = 7'b0010000,
    ST_WB   = 7'b0100000,
    ST_TOT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Input field unpacking
  func_e                in_func;
  logic [FieldIdxW-1:0] in_a, in_b, in_d;
  logic [DataW-1:0]     in_imm;
  logic                 dest_ok, srcs_ok, in_xfer;

  assign in_func = func_e'(s_axis_tdata[FuncW-1:0]);
  assign in_a    = s_axis_tdata[FuncW +: FieldIdxW];
  assign in_b    = s_axis_tdata[FuncW + FieldIdxW +: FieldIdxW];
  assign in_d    = s_axis_tdata[FuncW + 2*FieldIdxW +: FieldIdxW];
  assign in_imm  = s_axis_tdata[FuncW + 3*FieldIdxW +: DataW];
  assign dest_ok = {1'b0, in_d} < SlotLim;
  assign srcs_ok = dest_ok && ({1'b0, in_a} < SlotLim) && ({1'b0, in_b} < SlotLim);
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // Item registers
  func_e                func_q, func_d;
  logic [FieldIdxW-1:0] a_q, a_d, b_q, b_d, d_q, d_d;
  logic [DataW-1:0]     new_q, new_d, diff_q, diff_d, total_q, total_d;
  logic [DataW-1:0]     rval_q, rval_d;
  logic                 wr_q, wr_d, rvalid_q, rvalid_d;

  // Output register
  logic            ovld_q, ovld_d;
  logic [OutW-1:0] odata_q, odata_d;
  logic            out_free;

  assign out_free = !ovld_q || m_axis_tready;

  // Register file and arithmetic unit hookup
  logic [DataW-1:0] rd_a_data, rd_b_data, alu_res;
  logic             rf_wr_en;
  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;

  assign rf_wr_en      = (state_q == ST_WB) && wr_q;
  assign alu_req.start = (state_q == ST_OPS);
  assign alu_req.op    = func_q;

  rfac_regfile #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_a_addr_i ((state_q == ST_RDD) ? d_q[RfIdxW-1:0] : a_q[RfIdxW-1:0]),
    .rd_b_addr_i (b_q[RfIdxW-1:0]),
    .rd_a_data_o (rd_a_data),
    .rd_b_data_o (rd_b_data),
    .wr_en_i     (rf_wr_en),
    .wr_addr_i   (d_q[RfIdxW-1:0]),
    .wr_data_i   (new_q)
  );

  rfac_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (rd_a_data),
    .b_i    (rd_b_data),
    .rsp_o  (alu_rsp),
    .res_o  (alu_res)
  );

  // Sequencer
  always_comb begin
    state_d  = state_q;
    func_d   = func_q;
    a_d      = a_q;
    b_d      = b_q;
    d_d      = d_q;
    new_d    = new_q;
    diff_d   = diff_q;
    total_d  = total_q;
    rval_d   = rval_q;
    wr_d     = wr_q;
    rvalid_d = rvalid_q;
    ovld_d   = ovld_q && !m_axis_tready;
    odata_d  = odata_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          func_d   = in_func;
          a_d      = in_a;
          b_d      = in_b;
          d_d      = in_d;
          new_d    = in_imm;
          diff_d   = '0;
          wr_d     = 1'b0;
          rvalid_d = 1'b0;
          state_d  = ST_TOT;
          case (in_func) inside
            FN_LOAD: begin
              if (dest_ok) begin
                wr_d    = 1'b1;
                state_d = ST_RDD;
              end
            end
            FN_READ: begin
              if (dest_ok) begin
                rvalid_d = 1'b1;
                state_d  = ST_RDD;
              end
            end
            FN_ADD, FN_SUB, FN_MUL, FN_DIV: begin
              if (srcs_ok) begin
                state_d = ST_RDAB;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RDAB: state_d = ST_OPS;
      ST_OPS:  state_d = ST_EXEC;
      ST_EXEC: begin
        if (alu_rsp.done) begin
          new_d   = alu_res;
          wr_d    = alu_rsp.wr_ok;
          state_d = ST_RDD;
        end
      end
      ST_RDD: state_d = ST_WB;
      ST_WB: begin
        // old dest contents are on read port A now
        rval_d  = rd_a_data;
        diff_d  = wr_q ? (new_q - rd_a_data) : '0;
        state_d = ST_TOT;
      end
      ST_TOT: begin
        if (out_free) begin
          total_d = total_q + diff_q;
          ovld_d  = 1'b1;
          odata_d = OutW'({total_d,
                           rvalid_q ? rval_q : {DataW{1'b0}},
                           rvalid_q ? d_q : {FieldIdxW{1'b0}},
                           rvalid_q});
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      total_q <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    a_q      <= a_d;
    b_q      <= b_d;
    d_q      <= d_d;
    new_q    <= new_d;
    diff_q   <= diff_d;
    rval_q   <= rval_d;
    wr_q     <= wr_d;
    rvalid_q <= rvalid_d;
    odata_q  <= odata_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = odata_q;

  // The running total moves only when a result is loaded
  a_total_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_TOT) |=> $stable(total_q))
    else $error("running total changed outside result load");

  // The arithmetic unit finishes only while the sequencer waits for it
  a_alu_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> (state_q == ST_EXEC))
    else $error("arithmetic done outside execute");

  // Slot writes only go to slots that exist
  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_wr_en |-> ({1'b0, d_q} < SlotLim))
    else $error("slot write out of range");

  // A read result is only ever produced by a read item
  a_read_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_TOT) && out_free && rvalid_q) |-> (func_q == FN_READ))
    else $error("read flag on a non-read item");

  // An accepted item holds off the next one: s_axis_tready is low in the next cycle
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready)
    else $error("second item accepted while busy");

endmodule

`default_nettype wire

@@ tb/rfac_result_checker.sv @@
`timescale 1ns / 1ps

// Watches both stream channels, mirrors the slot file and checks every result.
module rfac_result_checker import rfac_pkg::*; #(
  parameter int NUM_SLOTS = NumSlotsDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid,
  input  wire logic            s_axis_tready,
  // func[2:0], src_a[6:3], src_b[10:7], dest[14:11], immediate[46:15], zero pad
  input  wire logic [InW-1:0]  s_axis_tdata,
  input  wire logic            m_axis_tvalid,
  input  wire logic            m_axis_tready,
  // read_valid[0], read_index[4:1], read_value[36:5], slot_total[68:37], zero pad
  input  wire logic [OutW-1:0] m_axis_tdata,
  output int                   fail_count_o,
  output int                   pending_o
);

  // Packed so that it lines up with the low bits of m_axis_tdata
  typedef struct packed {
    logic [DataW-1:0]     slot_total;
    logic [DataW-1:0]     read_value;
    logic [FieldIdxW-1:0] read_index;
    logic                 read_valid;
  } calc_result_t;

  logic [DataW-1:0] slot_mirror [NUM_SLOTS];
  calc_result_t     due_results [$];
  int               fails = 0;

  // Apply one operation to the mirror and return the result it must produce
  function automatic calc_result_t compute_result(input logic [InW-1:0] item);
    logic [FuncW-1:0]     fn;
    logic [FieldIdxW-1:0] ia, ib, id;
    logic [DataW-1:0]     imm, opa, opb, mag_a, mag_b, quo;
    logic                 dest_ok, srcs_ok;
    calc_result_t         res;
    fn  = item[2:0];
    ia  = item[6:3];
    ib  = item[10:7];
    id  = item[14:11];
    imm = item[46:15];
    res = '0;
    dest_ok = id < NUM_SLOTS;
    srcs_ok = dest_ok && (ia < NUM_SLOTS) && (ib < NUM_SLOTS);
    case (fn)
      FN_LOAD: if (dest_ok) slot_mirror[id] = imm;
      FN_READ: if (dest_ok) begin
        res.read_valid = 1'b1;
        res.read_index = id;
        res.read_value = slot_mirror[id];
      end
      FN_ADD, FN_SUB, FN_MUL, FN_DIV: if (srcs_ok) begin
        opa = slot_mirror[ia];
        opb = slot_mirror[ib];
        case (fn)
          FN_ADD: slot_mirror[id] = opa + opb;
          FN_SUB: slot_mirror[id] = opa - opb;
          FN_MUL: slot_mirror[id] = opa * opb;
          default: if (opb != '0) begin
            // sign-magnitude divide, truncating toward zero; MIN / -1 wraps
            mag_a = opa[DataW-1] ? -opa : opa;
            mag_b = opb[DataW-1] ? -opb : opb;
            quo   = mag_a / mag_b;
            slot_mirror[id] = (opa[DataW-1] ^ opb[DataW-1]) ? -quo : quo;
          end
        endcase
      end
      default: ;
    endcase
    res.slot_total = '0;
    for (int k = 0; k < NUM_SLOTS; k++) res.slot_total += slot_mirror[k];
    return res;
  endfunction

  // Predict on input transfers, compare on output transfers
  always @(posedge clk_i) begin
    calc_result_t got, want;
    if (!rst_ni) begin
      for (int k = 0; k < NUM_SLOTS; k++) slot_mirror[k] = '0;
      due_results.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) due_results.push_back(compute_result(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[OutBits-1:0];
        if (due_results.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected result valid=%0b idx=%0d val=%h total=%h", $realtime,
                     got.read_valid, got.read_index, got.read_value, got.slot_total);
        end else begin
          want = due_results.pop_front();
          if (got.read_valid !== want.read_valid || got.read_index !== want.read_index ||
              got.read_value !== want.read_value || got.slot_total !== want.slot_total) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: result mismatch exp valid=%0b idx=%0d val=%h total=%h",
                       $realtime, want.read_valid, want.read_index, want.read_value,
                       want.slot_total);
              $display("    got valid=%0b idx=%0d val=%h total=%h",
                       got.read_valid, got.read_index, got.read_value, got.slot_total);
            end
          end
        end
      end
    end
    pending_o    <= due_results.size();
    fail_count_o <= fails;
  end

endmodule

@@ tb/tb_register_file_alu_calculator.sv @@
`timescale 1ns / 1ps

module tb_register_file_alu_calculator;
  import rfac_pkg::*;

  localparam int SLOTS          = NumSlotsDef;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int ITEMS_PER_PASS = 167;
  // codes the block must treat as no-ops
  localparam logic [FuncW-1:0] FN_SPARE_LO = 3'd6;
  localparam logic [FuncW-1:0] FN_SPARE_HI = 3'd7;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [InW-1:0]  s_axis_tdata;
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [OutW-1:0] m_axis_tdata;

  int   fail_count;
  int   pending;
  int   send_idle_pct = 26;
  int   recv_idle_pct = 68;
  int   idle_cycles   = 0;
  logic hold_rx       = 1'b0;

  register_file_alu_calculator #(.NUM_SLOTS(SLOTS)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  rfac_result_checker #(.NUM_SLOTS(SLOTS)) result_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Offer one operation and hold it until the transfer happens
  task automatic send_op(input logic [FuncW-1:0] fn, input logic [FieldIdxW-1:0] ia,
                         input logic [FieldIdxW-1:0] ib, input logic [FieldIdxW-1:0] id,
                         input logic [DataW-1:0] imm);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InW-InBits){1'b0}}, imm, id, ib, ia, fn};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop offering and wait until every predicted result is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Mostly in-range slot index, sometimes anything the field can hold
  function automatic logic [FieldIdxW-1:0] pick_index();
    if ($urandom_range(9) == 0) return FieldIdxW'($urandom_range(15));
    return FieldIdxW'($urandom_range(SLOTS - 1));
  endfunction

  // One random operation; counts reports whether it did any real work
  task automatic send_random(output bit counts);
    logic [FuncW-1:0]     fn;
    logic [FieldIdxW-1:0] ia, ib, id;
    logic [DataW-1:0]     imm;
    int                   pick;
    pick = $urandom_range(99);
    if (pick < 4)       fn = $urandom_range(1) ? FN_SPARE_HI : FN_SPARE_LO;
    else if (pick < 30) fn = FN_LOAD;
    else if (pick < 45) fn = FN_READ;
    else                fn = FuncW'(FN_ADD + $urandom_range(3));
    ia = pick_index();
    ib = pick_index();
    id = pick_index();
    case ($urandom_range(3))
      0: imm = $urandom;
      1: imm = $urandom_range(40) - 20;
      2: case ($urandom_range(3))
           0: imm = 32'h7FFF_FFFF;
           1: imm = 32'h8000_0000;
           2: imm = 32'hFFFF_FFFF;
           default: imm = 32'h0000_0001;
         endcase
      default: imm = $urandom >> $urandom_range(31);
    endcase
    counts = (fn <= FN_DIV) && (id < SLOTS) &&
             (fn <= FN_READ || (ia < SLOTS && ib < SLOTS));
    send_op(fn, ia, ib, id, imm);
  endtask

  // Result side: random backpressure, plus one long hold on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        m_axis_tready <= 1'b0;
        hold_rx       <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("register_file_alu_calculator test failed");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    bit counts;
    int done_items;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every operation, the corner cases
    send_op(FN_LOAD, 4'h0, 4'hF, 4'd0, 32'h7FFF_FFFF);
    send_op(FN_LOAD, 4'hF, 4'h0, 4'd1, 32'h8000_0000);
    send_op(FN_LOAD, 4'h5, 4'hA, 4'd2, 32'hFFFF_FFFF);
    send_op(FN_LOAD, 4'h0, 4'h0, 4'd3, 32'd7);
    send_op(FN_LOAD, 4'h0, 4'h0, 4'd9, 32'hFFFF_FFFE);
    send_op(FN_DIV,  4'd3, 4'd4, 4'd3, $urandom);      // divide by zero slot
    send_op(FN_READ, 4'h0, 4'h0, 4'd0, $urandom);
    send_op(FN_READ, 4'hF, 4'hF, 4'd9, $urandom);
    send_op(FN_ADD,  4'd0, 4'd0, 4'd4, $urandom);      // overflow wraps
    send_op(FN_SUB,  4'd1, 4'd3, 4'd5, $urandom);      // underflow wraps
    send_op(FN_MUL,  4'd0, 4'd0, 4'd6, $urandom);      // low half of product
    send_op(FN_MUL,  4'd1, 4'd2, 4'd7, $urandom);
    send_op(FN_DIV,  4'd1, 4'd2, 4'd8, $urandom);      // most negative / -1
    send_op(FN_DIV,  4'd3, 4'd9, 4'd4, $urandom);      // 7 / -2 truncates
    send_op(FN_DIV,  4'd9, 4'd3, 4'd5, $urandom);      // -2 / 7 gives zero
    send_op(FN_LOAD, 4'h0, 4'h0, 4'd15, 32'h1234_5678); // dest out of range
    send_op(FN_LOAD, 4'h0, 4'h0, 4'd10, 32'h0BAD_F00D);
    send_op(FN_ADD,  4'd10, 4'd0, 4'd2, $urandom);     // src_a out of range
    send_op(FN_SUB,  4'd0, 4'd15, 4'd2, $urandom);     // src_b out of range
    send_op(FN_READ, 4'h0, 4'h0, 4'd12, $urandom);     // read out of range
    send_op(FN_SPARE_LO, 4'd1, 4'd2, 4'd3, $urandom);
    send_op(FN_SPARE_HI, 4'hF, 4'hF, 4'hF, 32'hFFFF_FFFF);
    send_op(FN_READ, 4'h0, 4'h0, 4'd8, $urandom);
    send_op(FN_LOAD, 4'h0, 4'h0, 4'd0, 32'h0);
    drain_results();

    // random passes: receiver-heavy idling, sender-heavy idling, none
    for (int pass = 0; pass < 3; pass++) begin
      case (pass)
        0: begin send_idle_pct = 26; recv_idle_pct = 68; end
        1: begin send_idle_pct = 68; recv_idle_pct = 26; end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_rx <= 1'b1;  // long receiver hold while items keep coming
        end
      endcase
      done_items = 0;
      while (done_items < ITEMS_PER_PASS) begin
        send_random(counts);
        if (counts) done_items++;
        if (pass == 2 && done_items == 40 && counts) drain_results();
      end
      drain_results();
    end

    repeat (64) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("register_file_alu_calculator test passed");
    else
      $display("register_file_alu_calculator test failed");
    $finish;
  end

endmodule
